/* src/oads_pkg.sv */
// oads_pkg: shared types, codes and constants of the obstacle avoid drive sequencer
// no dependencies; imported by the channel interfaces and all modules but oads_queue
`timescale 1ns / 1ps
`default_nettype none

package oads_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int WHEEL_W         = 32;
	localparam int SAMPLE_W        = 8;
	localparam int SPEED_W         = 8;
	localparam int MAG_W           = 7;
	localparam int BACK_W          = 16;
	localparam int SPIN_W          = 15;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;
	localparam int STALL_W         = 4;

	// distance above 30 ends near, below 20 starts near; on the sample scale
	// only the linear segment crosses these: clear below 66, set from 77
	localparam logic [SAMPLE_W-1:0] NEAR_CLEAR_BELOW = 8'd66;
	localparam logic [SAMPLE_W-1:0] NEAR_SET_FROM    = 8'd77;

	localparam logic [STALL_W-1:0] STALL_MAX    = 4'd15;
	localparam logic [STALL_W-1:0] STALL_TRIP   = 4'd10;
	localparam int                 STALL_MARGIN = 10;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_FAST  = 3'd1,
		MODE_SLOW  = 3'd2,
		MODE_BACK  = 3'd3,
		MODE_TURNL = 3'd4,
		MODE_TURNR = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		SENSE_CLEAR = 3'd0,
		SENSE_BUMPL = 3'd1,
		SENSE_BUMPR = 3'd2,
		SENSE_NEARL = 3'd3,
		SENSE_NEARR = 3'd4
	} sense_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FAST_SPEED    = 3'd0,
		CFG_SLOW_SPEED    = 3'd1,
		CFG_REVERSE_SPEED = 3'd2,
		CFG_REV_TURN      = 3'd3,
		CFG_SPIN_SPEED    = 3'd4,
		CFG_BACK_TICKS    = 3'd5,
		CFG_SPIN_TICKS    = 3'd6,
		CFG_BATTERY_MIN   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [MAG_W-1:0]    fast_speed;
		logic [MAG_W-1:0]    slow_speed;
		logic [SPEED_W-1:0]  reverse_speed;
		logic [MAG_W-1:0]    reverse_turn_speed;
		logic [MAG_W-1:0]    spin_speed;
		logic [BACK_W-1:0]   back_ticks;
		logic [SPIN_W-1:0]   spin_ticks;
		logic [SAMPLE_W-1:0] battery_min;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		fast_speed:         7'd80,
		slow_speed:         7'd30,
		reverse_speed:      8'hE2,
		reverse_turn_speed: 7'd15,
		spin_speed:         7'd25,
		back_ticks:         16'd80,
		spin_ticks:         15'd45,
		battery_min:        8'd100
	};

	// per-beat control word handed from front to back
	typedef struct packed {
		logic   low_batt;
		logic   start;
		sense_t cls;
	} item_ctrl_t;

	localparam int CTRL_W = $bits(item_ctrl_t);

	function automatic logic near_next(input logic cur, input logic [SAMPLE_W-1:0] s);
		logic r;
		if (s < NEAR_CLEAR_BELOW)
			r = 1'b0;
		else if (s >= NEAR_SET_FROM)
			r = 1'b1;
		else
			r = cur;
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/oads_channels.sv */
// oads_sense_if and oads_drive_if: valid/ready channels for sensor beats and command beats
// depends on oads_pkg
`timescale 1ns / 1ps
`default_nettype none

interface oads_sense_if;
	import oads_pkg::*;
	logic                valid;
	logic                ready;
	logic                bump_left;
	logic                bump_right;
	logic [SAMPLE_W-1:0] range_left_sample;
	logic [SAMPLE_W-1:0] range_right_sample;
	logic                start_pressed;
	logic [WHEEL_W-1:0]  wheel_count_left;
	logic [WHEEL_W-1:0]  wheel_count_right;
	logic [SAMPLE_W-1:0] battery_level;

	modport source (
		output valid, bump_left, bump_right, range_left_sample, range_right_sample,
		       start_pressed, wheel_count_left, wheel_count_right, battery_level,
		input  ready
	);
	modport sink (
		input  valid, bump_left, bump_right, range_left_sample, range_right_sample,
		       start_pressed, wheel_count_left, wheel_count_right, battery_level,
		output ready
	);
endinterface

interface oads_drive_if;
	import oads_pkg::*;
	logic               valid;
	logic               ready;
	logic signed [SPEED_W-1:0] drive_speed;
	logic signed [SPEED_W-1:0] steer_speed;
	logic               command_valid;
	logic [2:0]         drive_mode;
	logic [2:0]         sensor_class;

	modport source (
		output valid, drive_speed, steer_speed, command_valid, drive_mode, sensor_class,
		input  ready
	);
	modport sink (
		input  valid, drive_speed, steer_speed, command_valid, drive_mode, sensor_class,
		output ready
	);
endinterface

`default_nettype wire

/* src/oads_front.sv */
// oads_front: takes sensor beats, tracks near flags and wheel counts, classifies
// depends on oads_pkg and oads_sense_if; feeds oads_queue
`timescale 1ns / 1ps
`default_nettype none

module oads_front #(
	parameter int COUNT_WIDTH = oads_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	oads_sense_if.sink                        sensors,
	input  wire logic [oads_pkg::SAMPLE_W-1:0] battery_min,
	input  wire logic                         q_ready,
	output logic                              push,
	output logic [oads_pkg::CTRL_W+2*COUNT_WIDTH-1:0] push_data
);
	import oads_pkg::*;

	logic                   near_left_q, near_right_q;
	logic [COUNT_WIDTH-1:0] last_left_q, last_right_q;
	logic                   near_left_n, near_right_n;
	logic [COUNT_WIDTH-1:0] now_left, now_right;
	logic [COUNT_WIDTH-1:0] diff_left, diff_right;
	logic [COUNT_WIDTH-1:0] sp_left, sp_right;
	item_ctrl_t             ctrl;

	assign sensors.ready = q_ready;
	assign push          = sensors.valid & q_ready;

	assign near_left_n  = near_next(near_left_q, sensors.range_left_sample);
	assign near_right_n = near_next(near_right_q, sensors.range_right_sample);

	assign now_left   = sensors.wheel_count_left[COUNT_WIDTH-1:0];
	assign now_right  = sensors.wheel_count_right[COUNT_WIDTH-1:0];
	assign diff_left  = now_left - last_left_q;
	assign diff_right = now_right - last_right_q;
	// count delta times four, wrapping in the count width
	assign sp_left    = {diff_left[COUNT_WIDTH-3:0], 2'b00};
	assign sp_right   = {diff_right[COUNT_WIDTH-3:0], 2'b00};

	always_comb begin
		ctrl.low_batt = sensors.battery_level < battery_min;
		ctrl.start    = sensors.start_pressed;
		if (sensors.bump_left)
			ctrl.cls = SENSE_BUMPL;
		else if (sensors.bump_right)
			ctrl.cls = SENSE_BUMPR;
		else if (near_right_n)
			ctrl.cls = SENSE_NEARR;
		else if (near_left_n)
			ctrl.cls = SENSE_NEARL;
		else
			ctrl.cls = SENSE_CLEAR;
	end

	assign push_data = {ctrl, sp_left, sp_right};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_left_q  <= 1'b0;
			near_right_q <= 1'b0;
			last_left_q  <= '0;
			last_right_q <= '0;
		end else if (push) begin
			near_left_q  <= near_left_n;
			near_right_q <= near_right_n;
			last_left_q  <= now_left;
			last_right_q <= now_right;
		end
	end

endmodule

`default_nettype wire

/* src/oads_queue.sv */
// oads_queue: short flip-flop queue between front and back
// depends on nothing beyond its parameters
`timescale 1ns / 1ps
`default_nettype none

module oads_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	output logic                   push_ready,
	input  wire logic              pop,
	output logic [DATA_W-1:0]      pop_data,
	output logic                   pop_valid
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push, do_pop;

	assign push_ready = count_q != FULL;
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push & push_ready;
	assign do_pop     = pop & pop_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

/* src/oads_back.sv */
// oads_back: drive mode sequencer, stall watch and command output register
// depends on oads_pkg and oads_drive_if; drained from oads_queue
`timescale 1ns / 1ps
`default_nettype none

module oads_back #(
	parameter int COUNT_WIDTH = oads_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire oads_pkg::cfg_t                           cfg,
	input  wire logic                                     q_valid,
	input  wire logic [oads_pkg::CTRL_W+2*COUNT_WIDTH-1:0] q_data,
	output logic                                          pop,
	oads_drive_if.source                                  commands
);
	import oads_pkg::*;

	localparam int DW = CTRL_W + 2 * COUNT_WIDTH;

	item_ctrl_t                      ctrl;
	logic signed [COUNT_WIDTH-1:0]   sp_left, sp_right, lim;

	mode_t                       mode_q, mode_n, after_q, after_n;
	sense_t                      sense_q, sense_n;
	logic signed [SPEED_W-1:0]   fwd_q, fwd_n, turn_q, turn_n;
	logic [SPIN_W-1:0]           spin_q, spin_n, spin_dec;
	logic [BACK_W-1:0]           backoff_q, backoff_n;
	logic [STALL_W-1:0]          stall_q, stall_n;
	logic                        send, trans, stall_on, stall_trip, stop;
	logic                        is_near, is_bump;
	logic signed [SPEED_W-1:0]   fast_s, slow_s, rev_s, rts_s, spin_s;

	logic                        out_valid_q;
	logic signed [SPEED_W-1:0]   drive_q, steer_q;
	logic                        cmd_valid_q;
	mode_t                       mode_out_q;
	sense_t                      sense_out_q;

	assign ctrl     = item_ctrl_t'(q_data[DW-1 -: CTRL_W]);
	assign sp_left  = $signed(q_data[2*COUNT_WIDTH-1:COUNT_WIDTH]);
	assign sp_right = $signed(q_data[COUNT_WIDTH-1:0]);

	assign pop = q_valid & (~out_valid_q | commands.ready);

	assign fast_s = $signed({1'b0, cfg.fast_speed});
	assign slow_s = $signed({1'b0, cfg.slow_speed});
	assign rev_s  = $signed(cfg.reverse_speed);
	assign rts_s  = $signed({1'b0, cfg.reverse_turn_speed});
	assign spin_s = $signed({1'b0, cfg.spin_speed});

	assign trans    = ctrl.cls != sense_q;
	assign is_near  = ctrl.cls inside {SENSE_NEARL, SENSE_NEARR};
	assign is_bump  = ctrl.cls inside {SENSE_BUMPL, SENSE_BUMPR};
	assign spin_dec = (spin_q != '0) ? spin_q - 1'b1 : spin_q;
	assign sense_n  = ctrl.low_batt ? sense_q : ctrl.cls;

	// stall watch
	assign lim = $signed({{(COUNT_WIDTH-SPEED_W){fwd_q[SPEED_W-1]}}, fwd_q})
	             - COUNT_WIDTH'(STALL_MARGIN);
	assign stall_on = ~ctrl.low_batt & (fwd_q > 0);
	always_comb begin
		stall_n = stall_q;
		if (stall_on) begin
			if (sp_left < lim || sp_right < lim)
				stall_n = (stall_q == STALL_MAX) ? stall_q : stall_q + 1'b1;
			else
				stall_n = '0;
		end
	end
	assign stall_trip = stall_on & (stall_n > STALL_TRIP);
	assign stop       = ctrl.low_batt | stall_trip;

	// next mode and send decision
	always_comb begin
		mode_n = mode_q;
		send   = 1'b1;
		if (stop) begin
			mode_n = MODE_IDLE;
			send   = 1'b0;
		end else begin
			unique case (mode_q) inside
				MODE_IDLE: begin
					if (ctrl.start) begin
						if (ctrl.cls == SENSE_CLEAR)
							mode_n = MODE_FAST;
						else if (is_near)
							mode_n = MODE_SLOW;
						else
							mode_n = MODE_BACK;
					end
				end
				MODE_FAST: begin
					if (trans && is_near) begin
						mode_n = MODE_SLOW;
						send   = 1'b0;
					end else if (trans && is_bump) begin
						mode_n = MODE_BACK;
						send   = 1'b0;
					end
				end
				MODE_SLOW: begin
					if (trans && ctrl.cls == SENSE_CLEAR)
						mode_n = MODE_FAST;
					else if (trans && is_bump) begin
						mode_n = MODE_BACK;
						send   = 1'b0;
					end
				end
				MODE_BACK: begin
					if (backoff_q == '0 && ctrl.cls == SENSE_CLEAR) begin
						mode_n = after_q;
						send   = 1'b0;
					end
				end
				MODE_TURNL, MODE_TURNR: begin
					if (ctrl.cls == SENSE_BUMPR) begin
						mode_n = MODE_TURNL;
						send   = 1'b0;
					end else if (ctrl.cls == SENSE_BUMPL && mode_q == MODE_TURNL) begin
						mode_n = MODE_TURNR;
						send   = 1'b0;
					end else if (spin_dec == '0)
						mode_n = MODE_FAST;
				end
				default: ;
			endcase
		end
	end

	// commands and counters
	always_comb begin
		fwd_n     = fwd_q;
		turn_n    = turn_q;
		spin_n    = spin_q;
		backoff_n = backoff_q;
		after_n   = after_q;
		if (stop) begin
			fwd_n  = '0;
			turn_n = '0;
		end else begin
			unique case (mode_q) inside
				MODE_IDLE: begin
					if (!ctrl.start) begin
						fwd_n  = '0;
						turn_n = '0;
					end else if (is_bump) begin
						spin_n    = cfg.spin_ticks;
						backoff_n = cfg.back_ticks;
					end
				end
				MODE_FAST: begin
					if (trans) begin
						if (is_near) begin
							fwd_n  = slow_s;
							turn_n = '0;
						end else if (is_bump) begin
							after_n   = (ctrl.cls == SENSE_BUMPL) ? MODE_TURNR : MODE_TURNL;
							spin_n    = cfg.spin_ticks;
							backoff_n = cfg.back_ticks;
							fwd_n     = rev_s;
							turn_n    = (ctrl.cls == SENSE_BUMPL) ? -rts_s : rts_s;
						end
					end else begin
						if (fwd_q < fast_s)
							fwd_n = fwd_q + 8'sd1;
						else if (fwd_q > fast_s)
							fwd_n = fwd_q - 8'sd1;
						turn_n = '0;
					end
				end
				MODE_SLOW: begin
					if (trans && is_bump) begin
						spin_n    = cfg.spin_ticks;
						backoff_n = cfg.back_ticks;
						fwd_n     = rev_s;
						turn_n    = '0;
					end
				end
				MODE_BACK: begin
					if (backoff_q != '0)
						backoff_n = backoff_q - 1'b1;
					else if (ctrl.cls == SENSE_CLEAR) begin
						fwd_n  = '0;
						turn_n = '0;
					end
				end
				MODE_TURNL, MODE_TURNR: begin
					turn_n = (mode_q == MODE_TURNL) ? -spin_s : spin_s;
					if (!(ctrl.cls == SENSE_BUMPR
					      || (ctrl.cls == SENSE_BUMPL && mode_q == MODE_TURNL)))
						spin_n = spin_dec;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			after_q     <= MODE_IDLE;
			sense_q     <= SENSE_CLEAR;
			fwd_q       <= '0;
			turn_q      <= '0;
			spin_q      <= '0;
			backoff_q   <= '0;
			stall_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q    <= mode_n;
				after_q   <= after_n;
				sense_q   <= sense_n;
				fwd_q     <= fwd_n;
				turn_q    <= turn_n;
				spin_q    <= spin_n;
				backoff_q <= backoff_n;
				stall_q   <= stall_n;
			end
			if (pop)
				out_valid_q <= 1'b1;
			else if (commands.ready)
				out_valid_q <= 1'b0;
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (pop) begin
			drive_q     <= send ? fwd_n : '0;
			steer_q     <= send ? turn_n : '0;
			cmd_valid_q <= send;
			mode_out_q  <= mode_n;
			sense_out_q <= sense_n;
		end
	end

	assign commands.valid         = out_valid_q;
	assign commands.drive_speed   = drive_q;
	assign commands.steer_speed   = steer_q;
	assign commands.command_valid = cmd_valid_q;
	assign commands.drive_mode    = mode_out_q;
	assign commands.sensor_class  = sense_out_q;

endmodule

`default_nettype wire

/* src/obstacle_avoid_drive_sequencer.sv */
// obstacle_avoid_drive_sequencer: top level, configuration registers and the
// front / queue / back chain; depends on oads_pkg, oads_channels, oads_front,
// oads_queue and oads_back
//
//   channel    dir   handshake       payload
//   sensors    in    valid / ready   bumpers, range bytes, start, wheel counts, battery
//   commands   out   valid / ready   drive, steer, command_valid, mode, class
//   cfg        in    cfg_we          cfg_index, cfg_data
//
// one sensor beat per cycle sustained while commands are ready; a beat is written to
// the queue at the edge it is taken; its command beat is registered as it is popped
// the back end updates its mode state once per beat, one per cycle while not stalled
// reset is asynchronous; control state clears at once, no clearing pass
// a stalled command beat holds in the output register while the queue
// keeps taking sensor beats until it fills
`timescale 1ns / 1ps
`default_nettype none

module obstacle_avoid_drive_sequencer #(
	parameter int COUNT_WIDTH = oads_pkg::COUNT_WIDTH_DEF,
	parameter int QUEUE_DEPTH = oads_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [oads_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [oads_pkg::CFG_DATA_W-1:0] cfg_data,
	oads_sense_if.sink                           sensors,
	oads_drive_if.source                         commands
);
	import oads_pkg::*;

	localparam int DW = CTRL_W + 2 * COUNT_WIDTH;

	cfg_t          cfg_q;
	logic          push, q_ready, q_valid, pop;
	logic [DW-1:0] push_data, q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FAST_SPEED:    cfg_q.fast_speed         <= cfg_data[MAG_W-1:0];
				CFG_SLOW_SPEED:    cfg_q.slow_speed         <= cfg_data[MAG_W-1:0];
				CFG_REVERSE_SPEED: cfg_q.reverse_speed      <= cfg_data[SPEED_W-1:0];
				CFG_REV_TURN:      cfg_q.reverse_turn_speed <= cfg_data[MAG_W-1:0];
				CFG_SPIN_SPEED:    cfg_q.spin_speed         <= cfg_data[MAG_W-1:0];
				CFG_BACK_TICKS:    cfg_q.back_ticks         <= cfg_data[BACK_W-1:0];
				CFG_SPIN_TICKS:    cfg_q.spin_ticks         <= cfg_data[SPIN_W-1:0];
				CFG_BATTERY_MIN:   cfg_q.battery_min        <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	oads_front #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sensors     (sensors),
		.battery_min (cfg_q.battery_min),
		.q_ready     (q_ready),
		.push        (push),
		.push_data   (push_data)
	);

	oads_queue #(
		.DATA_W (DW),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (q_ready),
		.pop        (pop),
		.pop_data   (q_data),
		.pop_valid  (q_valid)
	);

	oads_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.pop      (pop),
		.commands (commands)
	);

endmodule

`default_nettype wire
